// File: hw/rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, constants and helpers for the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

   localparam int PAGE_W        = 20;      // page number width
   localparam int LIM_W         = 21;      // heap limit width (exclusive bound)
   localparam int MAP_WORD_W    = 32;      // bits per map word
   localparam int BIT_SEL_W     = 5;       // bit index inside a map word
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam int NUM_PAGES_DEF = 1048576;
   localparam int MAP_WORDS_DEF = (NUM_PAGES_DEF + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int WORD_ADDR_DEF = $clog2(MAP_WORDS_DEF);

   localparam logic [PAGE_W-1:0] HEAP_BASE_RST  = 20'd262144;
   localparam logic [LIM_W-1:0]  HEAP_LIMIT_RST = 21'd1048576;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 2'd1;

   // request commands
   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_ALLOC   = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_USED   = 2'd1;
   localparam logic [1:0] ST_NOFREE = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [PAGE_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] result_page;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } map_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_SEL_W-1:0] pos;
   } zscan_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RMW   = 4'b0010,
      S_ALLOC = 4'b0100,
      S_CLEAR = 4'b1000
   } state_type;

   // lowest clear bit of a map word
   function automatic zscan_type first_zero(input logic [MAP_WORD_W-1:0] used);
      zscan_type r;
      r.found = 1'b0;
      r.pos   = '0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (!used[i]) begin
            r.found = 1'b1;
            r.pos   = BIT_SEL_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/pfba_map_ram.sv
// ----------------------------------------------------------------------------
// pfba_map_ram
// Single-port used-page map, one word per 32 pages, registered read data.
// ----------------------------------------------------------------------------
module pfba_map_ram import pfba_pkg::*; #(
   parameter int DEPTH  = MAP_WORDS_DEF,
   parameter int ADDR_W = WORD_ADDR_DEF
) (
   input  logic                  clock,
   input  map_ctl_type           map_ctl,
   input  logic [ADDR_W-1:0]     addr,
   input  logic [MAP_WORD_W-1:0] wdata,
   output logic [MAP_WORD_W-1:0] rdata
);

   logic [MAP_WORD_W-1:0] mem [DEPTH];
   logic [MAP_WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (map_ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (map_ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: hw/rtl/pfba_ctrl.sv
// ----------------------------------------------------------------------------
// pfba_ctrl
// Command sequencer: read-modify-write, allocate scan, clearing sweep and
// the response register.
// ----------------------------------------------------------------------------
module pfba_ctrl import pfba_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   parameter int MAP_WORDS = (NUM_PAGES + MAP_WORD_W - 1) / MAP_WORD_W,
   parameter int WORD_W    = $clog2(MAP_WORDS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic [PAGE_W-1:0]     heap_base,
   input  logic [LIM_W-1:0]      heap_limit,
   output map_ctl_type           map_ctl,
   output logic [WORD_W-1:0]     map_addr,
   output logic [MAP_WORD_W-1:0] map_wdata,
   input  logic [MAP_WORD_W-1:0] map_rdata
);

   localparam logic [LIM_W-1:0]  NP_LIM    = LIM_W'(NUM_PAGES);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [1:0]            op_cmd_ff, op_cmd_in;
   logic [PAGE_W-1:0]     op_page_ff, op_page_in;
   logic                  oor_ff, oor_in;
   logic                  empty_ff, empty_in;
   logic [WORD_W-1:0]     first_word_ff, first_word_in;
   logic [WORD_W-1:0]     last_word_ff, last_word_in;
   logic [BIT_SEL_W-1:0]  base_bit_ff, base_bit_in;
   logic [BIT_SEL_W-1:0]  last_bit_ff, last_bit_in;
   logic [WORD_W-1:0]     chk_ff, chk_in;
   logic [WORD_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  clr_rsp_ff, clr_rsp_in;

   logic                  out_free;
   logic                  accept;
   logic                  req_oor;
   logic [LIM_W-1:0]      lim_eff;
   logic [LIM_W-1:0]      lim_m1;
   logic                  win_empty;
   logic [MAP_WORD_W-1:0] page_bit;
   logic [MAP_WORD_W-1:0] used;
   zscan_type             zs;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   assign req_oor   = ({1'b0, req_data.page_number} >= NP_LIM);
   assign lim_eff   = (heap_limit < NP_LIM) ? heap_limit : NP_LIM;
   assign lim_m1    = lim_eff - LIM_W'(1);
   assign win_empty = ({1'b0, heap_base} >= lim_eff);
   assign page_bit  = MAP_WORD_W'(1) << op_page_ff[BIT_SEL_W-1:0];

   // pages below the base and at or above the limit count as used
   always_comb begin
      used = map_rdata;
      if (chk_ff == first_word_ff) begin
         used = used | ~({MAP_WORD_W{1'b1}} << base_bit_ff);
      end
      if (chk_ff == last_word_ff) begin
         used = used | ({{(MAP_WORD_W-1){1'b1}}, 1'b0} << last_bit_ff);
      end
   end

   assign zs = first_zero(used);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      op_cmd_in     = op_cmd_ff;
      op_page_in    = op_page_ff;
      oor_in        = oor_ff;
      empty_in      = empty_ff;
      first_word_in = first_word_ff;
      last_word_in  = last_word_ff;
      base_bit_in   = base_bit_ff;
      last_bit_in   = last_bit_ff;
      chk_in        = chk_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      map_ctl       = '0;
      map_addr      = chk_ff;
      map_wdata     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_cmd_in     = req_data.cmd;
               op_page_in    = req_data.page_number;
               oor_in        = req_oor;
               empty_in      = win_empty;
               first_word_in = heap_base[WORD_W+BIT_SEL_W-1:BIT_SEL_W];
               last_word_in  = lim_m1[WORD_W+BIT_SEL_W-1:BIT_SEL_W];
               base_bit_in   = heap_base[BIT_SEL_W-1:0];
               last_bit_in   = lim_m1[BIT_SEL_W-1:0];
               case (req_data.cmd)
                  CMD_RESERVE, CMD_FREE: begin
                     map_ctl.rd_en = !req_oor;
                     map_addr      = req_data.page_number[WORD_W+BIT_SEL_W-1:BIT_SEL_W];
                     state_in      = S_RMW;
                  end
                  CMD_ALLOC: begin
                     map_ctl.rd_en = !win_empty;
                     map_addr      = heap_base[WORD_W+BIT_SEL_W-1:BIT_SEL_W];
                     chk_in        = heap_base[WORD_W+BIT_SEL_W-1:BIT_SEL_W];
                     state_in      = S_ALLOC;
                  end
                  default: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLEAR;
                  end
               endcase
            end
         end

         S_RMW: begin
            map_addr = op_page_ff[WORD_W+BIT_SEL_W-1:BIT_SEL_W];
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_page = op_page_ff;
               rsp_data_in.status      = ST_OK;
               if (op_cmd_ff == CMD_RESERVE) begin
                  if (oor_ff || ((map_rdata & page_bit) != '0)) begin
                     rsp_data_in.status = ST_USED;
                  end else begin
                     map_ctl.wr_en = 1'b1;
                     map_wdata     = map_rdata | page_bit;
                  end
               end else begin
                  map_ctl.wr_en = !oor_ff;
                  map_wdata     = map_rdata & ~page_bit;
               end
               state_in = S_IDLE;
            end
         end

         S_ALLOC: begin
            if (empty_ff || (!zs.found && (chk_ff == last_word_ff))) begin
               // hold until the response register frees
               if (out_free) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = ST_NOFREE;
                  rsp_data_in.result_page = '0;
                  state_in                = S_IDLE;
               end
            end else if (zs.found) begin
               if (out_free) begin
                  map_ctl.wr_en           = 1'b1;
                  map_addr                = chk_ff;
                  map_wdata               = map_rdata | (MAP_WORD_W'(1) << zs.pos);
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = ST_OK;
                  rsp_data_in.result_page = PAGE_W'({chk_ff, zs.pos});
                  state_in                = S_IDLE;
               end
            end else begin
               // advance one word per cycle
               map_ctl.rd_en = 1'b1;
               map_addr      = chk_ff + WORD_W'(1);
               chk_in        = chk_ff + WORD_W'(1);
            end
         end

         S_CLEAR: begin
            map_addr = clr_addr_ff;
            if (clr_addr_ff != LAST_WORD) begin
               map_ctl.wr_en = 1'b1;
               clr_addr_in   = clr_addr_ff + WORD_W'(1);
            end else if (!clr_rsp_ff) begin
               map_ctl.wr_en = 1'b1;
               state_in      = S_IDLE;
            end else if (out_free) begin
               map_ctl.wr_en           = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = ST_OK;
               rsp_data_in.result_page = '0;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      op_cmd_ff     <= op_cmd_in;
      op_page_ff    <= op_page_in;
      oor_ff        <= oor_in;
      empty_ff      <= empty_in;
      first_word_ff <= first_word_in;
      last_word_ff  <= last_word_in;
      base_bit_ff   <= base_bit_in;
      last_bit_ff   <= last_bit_in;
      chk_ff        <= chk_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/page_frame_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_unit
// Reserve and free: one read-modify-write of a map word per request.
// Allocate: scans the map a word at a time, starting at the heap base word.
// Clear: one map word written per cycle, the last one held until the response register frees.
// After reset all NUM_PAGES/32 map words (32768 by default) are swept to zero
// before the first request is taken; register writes go through.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_unit import pfba_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int WORD_W    = $clog2(MAP_WORDS);

   logic [PAGE_W-1:0]     heap_base_ff, heap_base_in;
   logic [LIM_W-1:0]      heap_limit_ff, heap_limit_in;
   map_ctl_type           map_ctl;
   logic [WORD_W-1:0]     map_addr;
   logic [MAP_WORD_W-1:0] map_wdata;
   logic [MAP_WORD_W-1:0] map_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      heap_base_in  = heap_base_ff;
      heap_limit_in = heap_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAP_BASE:  heap_base_in  = csr_wdata[PAGE_W-1:0];
            CSR_HEAP_LIMIT: heap_limit_in = csr_wdata[LIM_W-1:0];
            default: begin
               // drop writes to unmapped registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= HEAP_BASE_RST;
         heap_limit_ff <= HEAP_LIMIT_RST;
      end else begin
         heap_base_ff  <= heap_base_in;
         heap_limit_ff <= heap_limit_in;
      end
   end

   pfba_ctrl #(
      .NUM_PAGES (NUM_PAGES),
      .MAP_WORDS (MAP_WORDS),
      .WORD_W    (WORD_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .heap_base  (heap_base_ff),
      .heap_limit (heap_limit_ff),
      .map_ctl    (map_ctl),
      .map_addr   (map_addr),
      .map_wdata  (map_wdata),
      .map_rdata  (map_rdata)
   );

   pfba_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WORD_W)
   ) u_map_ram (
      .clock   (clock),
      .map_ctl (map_ctl),
      .addr    (map_addr),
      .wdata   (map_wdata),
      .rdata   (map_rdata)
   );

endmodule
